// ----- hw/rtl/dmm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and constants for the dense matrix multiply block.
// ----------------------------------------------------------------------------
package dmm_pkg;

   localparam int ELEM_W  = 16;             // Q1.15 element
   localparam int PROD_W  = 2 * ELEM_W;     // Q2.30 product
   localparam int VALUE_W = 35;             // Q5.30 sum
   localparam int INDEX_W = 3;              // row / column field width
   localparam int DIM_W   = 4;              // dimension register width
   localparam int ADDR_W  = 4;              // CSR byte address width
   localparam int DATA_W  = 32;             // CSR data width

   // request codes
   typedef enum logic [1:0] {
      REQ_LOAD_A  = 2'd0,
      REQ_LOAD_B  = 2'd1,
      REQ_COMPUTE = 2'd2
   } req_code_type;

   // register indexes (word address)
   localparam logic [1:0] REG_A_ROWS    = 2'd0;
   localparam logic [1:0] REG_INNER_LEN = 2'd1;
   localparam logic [1:0] REG_B_COLS    = 2'd2;

   typedef struct packed {
      logic [1:0]                req_type;
      logic [INDEX_W-1:0]        elem_row;
      logic [INDEX_W-1:0]        elem_col;
      logic signed [ELEM_W-1:0]  elem_value;
   } dmm_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] prod_value;
      logic [INDEX_W-1:0]        prod_row;
      logic [INDEX_W-1:0]        prod_col;
      logic                      last;
   } dmm_rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] a_rows;
      logic [DIM_W-1:0] inner_len;
      logic [DIM_W-1:0] b_cols;
   } dmm_dims_type;

   // partial sum traveling down the cell chain
   typedef struct packed {
      logic                      valid;
      logic [INDEX_W-1:0]        row;
      logic [INDEX_W-1:0]        col;
      logic                      last;
      logic signed [VALUE_W-1:0] sum;
   } dmm_token_type;

   // element write broadcast to every cell
   typedef struct packed {
      logic                     a_we;
      logic                     b_we;
      logic [INDEX_W-1:0]       row;
      logic [INDEX_W-1:0]       col;
      logic signed [ELEM_W-1:0] value;
   } dmm_load_type;

endpackage : dmm_pkg
`default_nettype wire

// ----- hw/rtl/dmm_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmm_csr
// APB-style register file holding the three matrix dimensions.
// ----------------------------------------------------------------------------
module dmm_csr
   import dmm_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready,
   output dmm_dims_type           dims
);

   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

   dmm_dims_type      dims_ff;
   dmm_dims_type      dims_in;
   logic              wr_en;
   logic [DIM_W-1:0]  wr_dim;
   logic [1:0]        reg_idx;

   // hold a written dimension inside 1..MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end
      return r;
   endfunction

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign wr_dim     = clamp_dim(csr_pwdata[DIM_W-1:0]);

   always_comb begin
      dims_in = dims_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_A_ROWS:    dims_in.a_rows    = wr_dim;
            REG_INNER_LEN: dims_in.inner_len = wr_dim;
            REG_B_COLS:    dims_in.b_cols    = wr_dim;
            default:       dims_in = dims_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= '{a_rows: DIM_MAX, inner_len: DIM_MAX, b_cols: DIM_MAX};
      end else begin
         dims_ff <= dims_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_A_ROWS:    csr_prdata = DATA_W'(dims_ff.a_rows);
         REG_INNER_LEN: csr_prdata = DATA_W'(dims_ff.inner_len);
         REG_B_COLS:    csr_prdata = DATA_W'(dims_ff.b_cols);
         default:       csr_prdata = '0;
      endcase
   end

   assign dims = dims_ff;

endmodule : dmm_csr
`default_nettype wire

// ----- hw/rtl/dmm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmm_cell
// One multiply-accumulate cell for inner index CELL_IDX: holds column
// CELL_IDX of A and row CELL_IDX of B, adds one product to a passing sum.
// ----------------------------------------------------------------------------
module dmm_cell
   import dmm_pkg::*;
#(
   parameter int MAX_DIM  = 8,
   parameter int CELL_IDX = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic [DIM_W-1:0] inner_len,
   input  wire dmm_load_type     load,
   input  wire dmm_token_type    tok_in,
   output dmm_token_type         tok_out
);

   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [INDEX_W-1:0] MY_IDX = INDEX_W'(CELL_IDX);

   logic signed [ELEM_W-1:0]  a_col_ff [MAX_DIM];
   logic signed [ELEM_W-1:0]  b_row_ff [MAX_DIM];
   logic signed [ELEM_W-1:0]  a_rd;
   logic signed [ELEM_W-1:0]  b_rd;
   logic signed [PROD_W-1:0]  prod;
   logic signed [VALUE_W-1:0] term;
   logic                      active;
   dmm_token_type             tok_ff;
   dmm_token_type             tok_in_nxt;

   // A[i][k] by row i, B[k][j] by column j
   assign a_rd   = a_col_ff[tok_in.row[IDX_W-1:0]];
   assign b_rd   = b_row_ff[tok_in.col[IDX_W-1:0]];
   assign prod   = a_rd * b_rd;
   assign active = DIM_W'(CELL_IDX) < inner_len;
   assign term   = active ? {{(VALUE_W-PROD_W){prod[PROD_W-1]}}, prod} : '0;

   always_comb begin
      tok_in_nxt     = tok_in;
      tok_in_nxt.sum = tok_in.sum + term;
   end

   always_ff @(posedge clock) begin
      if (load.a_we && load.col == MY_IDX) begin
         a_col_ff[load.row[IDX_W-1:0]] <= load.value;
      end
      if (load.b_we && load.row == MY_IDX) begin
         b_row_ff[load.col[IDX_W-1:0]] <= load.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff.valid <= tok_in.valid;
      end
      // payload holds no reset
      if (advance) begin
         tok_ff.row  <= tok_in_nxt.row;
         tok_ff.col  <= tok_in_nxt.col;
         tok_ff.last <= tok_in_nxt.last;
         tok_ff.sum  <= tok_in_nxt.sum;
      end
   end

   assign tok_out = tok_ff;

endmodule : dmm_cell
`default_nettype wire

// ----- hw/rtl/dense_matrix_multiply.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// Dense product C = A x B of Q1.15 matrices up to MAX_DIM x MAX_DIM, with
// exact Q5.30 sums streamed out row-major.
// ----------------------------------------------------------------------------
// Load transfers (req_type load A / load B) write one element into the cell
// chain; loads with an index not below MAX_DIM and request code 3 are
// dropped without a result. A compute transfer issues one (row, col) token
// per advancing cycle into a chain of MAX_DIM multiply-accumulate cells; cell
// k adds A[row][k] * B[k][col] and hands the partial sum to cell k+1, so one
// C element leaves the chain per advancing cycle. While rsp_ready is held low
// the whole chain stalls with the output register. The next request is taken
// once issuing is done and the chain has drained; a finished result may still
// wait in the output register. Dimensions are written over the APB-style port
// (a_rows at 0x0, inner_len at 0x4, b_cols at 0x8; 0 reads back as 1, values
// above MAX_DIM as MAX_DIM); the user must write them only while the block is
// idle, which the block itself does not enforce. Every entry of A and B that
// a compute touches must have been loaded since reset.
// ----------------------------------------------------------------------------
module dense_matrix_multiply
   import dmm_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dmm_req_type       req_data,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dmm_rsp_type            rsp_data,
   // configuration port
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic {
      ST_IDLE,
      ST_ISSUE
   } state_type;

   dmm_dims_type       dims;
   dmm_load_type       load;
   dmm_token_type      tok [MAX_DIM+1];
   logic [MAX_DIM-1:0] cell_busy;

   state_type          state_ff,  state_in;
   logic [INDEX_W-1:0] row_ff,    row_in;
   logic [INDEX_W-1:0] col_ff,    col_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dmm_rsp_type        rsp_data_ff;

   logic               req_xfer;
   logic               advance;
   logic               in_range;
   logic               row_end;
   logic               col_end;

   // register file
   dmm_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dims        (dims)
   );

   // the chain and the output register move together; stall on a held result
   assign advance  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && (cell_busy == '0);
   assign req_xfer = req_valid && req_ready;

   // drop loads that fall outside the stores
   assign in_range = ({1'b0, req_data.elem_row} < DIM_W'(MAX_DIM)) &&
                     ({1'b0, req_data.elem_col} < DIM_W'(MAX_DIM));

   always_comb begin
      load.a_we  = req_xfer && in_range && (req_data.req_type == REQ_LOAD_A);
      load.b_we  = req_xfer && in_range && (req_data.req_type == REQ_LOAD_B);
      load.row   = req_data.elem_row;
      load.col   = req_data.elem_col;
      load.value = req_data.elem_value;
   end

   // issue sequencer: walk C row-major, one token per advancing cycle
   assign col_end = ({1'b0, col_ff} == dims.b_cols - DIM_W'(1));
   assign row_end = ({1'b0, row_ff} == dims.a_rows - DIM_W'(1));

   always_comb begin
      tok[0].valid = (state_ff == ST_ISSUE);
      tok[0].row   = row_ff;
      tok[0].col   = col_ff;
      tok[0].last  = row_end && col_end;
      tok[0].sum   = '0;
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_data.req_type == REQ_COMPUTE) begin
               state_in = ST_ISSUE;
               row_in   = '0;
               col_in   = '0;
            end
         end
         ST_ISSUE: begin
            if (advance) begin
               if (col_end) begin
                  col_in = '0;
                  row_in = row_ff + INDEX_W'(1);
                  if (row_end) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  col_in = col_ff + INDEX_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   // chain of multiply-accumulate cells, one per inner index
   for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
      dmm_cell #(
         .MAX_DIM  (MAX_DIM),
         .CELL_IDX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .inner_len (dims.inner_len),
         .load      (load),
         .tok_in    (tok[k]),
         .tok_out   (tok[k+1])
      );
      assign cell_busy[k] = tok[k+1].valid;
   end

   // output register: take the chain's tail whenever the chain advances
   assign rsp_valid_in = advance ? tok[MAX_DIM].valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.prod_value <= tok[MAX_DIM].sum;
         rsp_data_ff.prod_row   <= tok[MAX_DIM].row;
         rsp_data_ff.prod_col   <= tok[MAX_DIM].col;
         rsp_data_ff.last       <= tok[MAX_DIM].last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : dense_matrix_multiply
`default_nettype wire
